/* rtl/bear_pkg.sv */
// Shared types and constants for the button event auto-repeat block.
// Used by bear_time_unit, bear_seq and button_event_auto_repeat; depends on nothing.
`default_nettype none

package bear_pkg;

   // Number of buttons scanned, and the counter width that walks them.
   localparam int NUM_BUTTONS = 24;
   localparam int IDX_W       = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
   localparam int LAST_IDX    = NUM_BUTTONS - 1;

   // Field widths fixed by the interface.
   localparam int BITS_W  = 24;
   localparam int TIME_W  = 32;
   localparam int DELAY_W = 24;
   localparam int INDEX_W = 5;
   localparam int KIND_W  = 2;

   // Register file.
   localparam int CSR_ADDR_W = 1;
   localparam logic [CSR_ADDR_W-1:0] CSR_INITIAL_DELAY = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_REPEAT_DELAY  = 1'b1;
   localparam logic [DELAY_W-1:0] INITIAL_DELAY_RST = 24'd200;
   localparam logic [DELAY_W-1:0] REPEAT_DELAY_RST  = 24'd100;

   // Event codes.
   typedef enum logic [KIND_W-1:0] {
      KIND_PRESS   = 2'd0,
      KIND_RELEASE = 2'd1,
      KIND_REPEAT  = 2'd2
   } kind_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH
   } state_type;

   // Input transaction payload.
   typedef struct packed {
      logic [BITS_W-1:0] button_bits;
      logic [TIME_W-1:0] now_ticks;
   } req_type;

   // Result transaction payload.
   typedef struct packed {
      logic [INDEX_W-1:0] button_index;
      logic [KIND_W-1:0]  event_kind;
      logic               last_event;
   } rsp_type;

   // One event handed from the sequencer to the output register.
   typedef struct packed {
      logic    valid;
      rsp_type data;
   } emit_type;

endpackage

`default_nettype wire

/* rtl/button_event_auto_repeat.sv */
// Top level of the button event auto-repeat block: ports, delay registers
// and the result register. Uses bear_pkg and bear_seq.
//
// Each accepted sample is compared with the previous one and scanned one
// button per cycle unless the result channel stalls, lowest bit first, by a
// single sequencer sharing one time compare and add unit. A sample is
// accepted, each button is scanned and the final event is released, in that
// order; a stalled result channel holds the scan and the release. req_stall
// is high for the whole scan. Each button yields at most one press, release or
// repeat event; the last event of a sample carries last_event. Delay registers
// take effect at the next arming and are reset to 200 and 100 ticks.
`default_nettype none

module button_event_auto_repeat (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire bear_pkg::req_type                    req_data,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output bear_pkg::rsp_type                         rsp_data,
   input  wire logic                                 csr_wr_en,
   input  wire logic [bear_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  wire logic [bear_pkg::DELAY_W-1:0]         csr_wdata
);

   logic [bear_pkg::DELAY_W-1:0] initial_delay_ff, initial_delay_in;
   logic [bear_pkg::DELAY_W-1:0] repeat_delay_ff, repeat_delay_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   bear_pkg::rsp_type            rsp_data_ff, rsp_data_in;
   bear_pkg::emit_type           emit;
   logic                         busy, req_fire, out_free;

   // Input transaction handshake.
   assign req_stall = busy;
   assign req_fire  = req_valid & ~busy;

   // The result register can take a new transaction when empty or draining.
   assign out_free = ~rsp_valid_ff | ~rsp_stall;

   bear_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_fire      (req_fire),
      .req_data      (req_data),
      .initial_delay (initial_delay_ff),
      .repeat_delay  (repeat_delay_ff),
      .out_free      (out_free),
      .emit          (emit),
      .busy          (busy)
   );

   // Configuration register writes.
   always_comb begin
      initial_delay_in = initial_delay_ff;
      repeat_delay_in  = repeat_delay_ff;
      if (csr_wr_en) begin
         case (csr_addr)
            bear_pkg::CSR_INITIAL_DELAY: initial_delay_in = csr_wdata;
            bear_pkg::CSR_REPEAT_DELAY:  repeat_delay_in  = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Result register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (emit.valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = emit.data;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         initial_delay_ff <= bear_pkg::INITIAL_DELAY_RST;
         repeat_delay_ff  <= bear_pkg::REPEAT_DELAY_RST;
         rsp_valid_ff     <= 1'b0;
      end else begin
         initial_delay_ff <= initial_delay_in;
         repeat_delay_ff  <= repeat_delay_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

/* rtl/bear_time_unit.sv */
// Shared time arithmetic: wrap-safe due check and re-arm sum.
// Depends on bear_pkg for widths.
`default_nettype none

module bear_time_unit (
   input  wire logic [bear_pkg::TIME_W-1:0]  now_ticks,
   input  wire logic [bear_pkg::TIME_W-1:0]  due_time,
   input  wire logic [bear_pkg::DELAY_W-1:0] delay,
   output logic                              reached,
   output logic [bear_pkg::TIME_W-1:0]       rearm_time
);

   logic [bear_pkg::TIME_W-1:0] diff;

   // The due time has come when now - due, read as signed, is not negative.
   assign diff       = now_ticks - due_time;
   assign reached    = ~diff[bear_pkg::TIME_W-1];

   // Next due time is now plus the selected delay, wrapping.
   assign rearm_time = now_ticks + bear_pkg::TIME_W'(delay);

endmodule

`default_nettype wire

/* rtl/bear_seq.sv */
// Scan sequencer: walks the buttons one per cycle unless a full output holds
// it, keeps the per-button due times and holds back one event so the final
// one can be flagged. Uses bear_pkg and bear_time_unit.
`default_nettype none

module bear_seq (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_fire,
   input  wire bear_pkg::req_type                 req_data,
   input  wire logic [bear_pkg::DELAY_W-1:0]      initial_delay,
   input  wire logic [bear_pkg::DELAY_W-1:0]      repeat_delay,
   input  wire logic                              out_free,
   output bear_pkg::emit_type                     emit,
   output logic                                   busy
);

   localparam int N = bear_pkg::NUM_BUTTONS;
   localparam int W = bear_pkg::IDX_W;

   bear_pkg::state_type state_ff, state_in;

   logic [N-1:0]                  cur_ff, cur_in;
   logic [N-1:0]                  prev_ff, prev_in;
   logic [bear_pkg::TIME_W-1:0]   now_ff, now_in;
   logic [W-1:0]                  idx_ff, idx_in;
   logic                          pend_valid_ff, pend_valid_in;
   logic [W-1:0]                  pend_idx_ff, pend_idx_in;
   logic [bear_pkg::KIND_W-1:0]   pend_kind_ff, pend_kind_in;
   logic [bear_pkg::TIME_W-1:0]   due_ff [N];

   logic [31:0]                   req_bits_ext;
   logic                          cur_bit, prev_bit;
   logic                          is_press, is_release, is_held;
   logic                          reached, hit;
   logic [bear_pkg::KIND_W-1:0]   hit_kind;
   logic [bear_pkg::DELAY_W-1:0]  delay_sel;
   logic [bear_pkg::TIME_W-1:0]   rearm_time;
   logic                          step_ok, flush_done, last_step;

   // Sample bits above the field width read as released.
   assign req_bits_ext = 32'(req_data.button_bits);

   // Classify the button under the scan pointer.
   assign cur_bit    = cur_ff[idx_ff];
   assign prev_bit   = prev_ff[idx_ff];
   assign is_press   = cur_bit & ~prev_bit;
   assign is_release = prev_bit & ~cur_bit;
   assign is_held    = cur_bit & prev_bit;
   assign delay_sel  = is_press ? initial_delay : repeat_delay;

   bear_time_unit u_time (
      .now_ticks  (now_ff),
      .due_time   (due_ff[idx_ff]),
      .delay      (delay_sel),
      .reached    (reached),
      .rearm_time (rearm_time)
   );

   assign hit = is_press | is_release | (is_held & reached);

   always_comb begin
      if (is_press) begin
         hit_kind = bear_pkg::KIND_PRESS;
      end else if (is_release) begin
         hit_kind = bear_pkg::KIND_RELEASE;
      end else begin
         hit_kind = bear_pkg::KIND_REPEAT;
      end
   end

   assign last_step = (idx_ff == W'(bear_pkg::LAST_IDX));

   // Control outputs of the sequencer.
   always_comb begin
      step_ok    = 1'b0;
      flush_done = 1'b0;
      emit.valid = 1'b0;
      emit.data.button_index = bear_pkg::INDEX_W'(pend_idx_ff);
      emit.data.event_kind   = pend_kind_ff;
      emit.data.last_event   = 1'b0;
      case (state_ff)
         bear_pkg::ST_SCAN: begin
            // A new event pushes the held-back one out; wait if the output is full.
            step_ok    = ~(hit & pend_valid_ff & ~out_free);
            emit.valid = hit & pend_valid_ff & out_free;
         end
         bear_pkg::ST_FLUSH: begin
            flush_done = ~pend_valid_ff | out_free;
            emit.valid = pend_valid_ff & out_free;
            emit.data.last_event = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign busy = (state_ff != bear_pkg::ST_IDLE);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bear_pkg::ST_IDLE: begin
            if (req_fire) state_in = bear_pkg::ST_SCAN;
         end
         bear_pkg::ST_SCAN: begin
            if (step_ok && last_step) state_in = bear_pkg::ST_FLUSH;
         end
         bear_pkg::ST_FLUSH: begin
            if (flush_done) state_in = bear_pkg::ST_IDLE;
         end
         default: begin
            state_in = bear_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath register updates.
   always_comb begin
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      now_in        = now_ff;
      idx_in        = idx_ff;
      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;
      pend_kind_in  = pend_kind_ff;
      if (req_fire) begin
         cur_in = req_bits_ext[N-1:0];
         now_in = req_data.now_ticks;
         idx_in = '0;
      end
      if (step_ok) begin
         idx_in = idx_ff + W'(1);
         if (hit) begin
            pend_valid_in = 1'b1;
            pend_idx_in   = idx_ff;
            pend_kind_in  = hit_kind;
         end
      end
      if (flush_done) begin
         pend_valid_in = 1'b0;
         prev_in       = cur_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bear_pkg::ST_IDLE;
         prev_ff       <= '0;
         pend_valid_ff <= 1'b0;
         idx_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         prev_ff       <= prev_in;
         pend_valid_ff <= pend_valid_in;
         idx_ff        <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      now_ff       <= now_in;
      pend_idx_ff  <= pend_idx_in;
      pend_kind_ff <= pend_kind_in;
   end

   // Per-button due times; re-armed on a press or a repeat.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < N; i++) begin
            due_ff[i] <= '0;
         end
      end else if (step_ok && (is_press || (is_held && reached))) begin
         due_ff[idx_ff] <= rearm_time;
      end
   end

`ifndef NO_ASSERTIONS
   a_emit_has_pending: assert property (@(posedge clock) disable iff (reset)
      emit.valid |-> pend_valid_ff)
      else $error("event emitted with nothing held back");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bear_pkg::ST_SCAN) |-> (idx_ff <= W'(bear_pkg::LAST_IDX)))
      else $error("scan pointer beyond the last button");

   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      flush_done |=> (state_ff == bear_pkg::ST_IDLE) && !pend_valid_ff)
      else $error("flush did not return to idle with nothing pending");
`endif

endmodule

`default_nettype wire
